// ===== rtl/core/caption_display_order_reorder_buffer_defines.svh =====
// Assertion macros used by the reorder buffer checker.
`ifndef CAPTION_DISPLAY_ORDER_REORDER_BUFFER_DEFINES_SVH
`define CAPTION_DISPLAY_ORDER_REORDER_BUFFER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CDORB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CDORB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cdorb_pkg.sv =====
// Types and constants of the caption display-order reorder buffer.
`default_nettype none
package cdorb_pkg;
    localparam int HOLD_DEPTH_DEF     = 32;
    localparam int BACKJUMP_LIMIT_DEF = 30;
    localparam int SEQ_W              = 11;
    localparam int LEN_W              = 10;
    localparam int MIN_LEN            = 5;
    localparam int S_TDATA_W          = 104;
    localparam int S_TUSER_W          = 5;
    localparam int M_TDATA_W          = 64;
    localparam logic [2:0] PTYPE_I    = 3'd1;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] ftime;
        logic        sv;
        logic [9:0]  order;
        logic [9:0]  len;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic   emit;
        logic   finish;
        entry_t ent;
    } emit_req_t;

    typedef struct packed {
        logic drop;
        logic ins;
    } store_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FLUSH, ST_DECIDE, ST_RUN, ST_FULL,
        ST_BACK, ST_SEARCH, ST_INSERT, ST_FINISH
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/cdorb_store.sv =====
// Hold list: sorted entries, shift-up insert, shift-down head drop, two read ports.
`default_nettype none
module cdorb_store #(
    parameter int HOLD_DEPTH = cdorb_pkg::HOLD_DEPTH_DEF
) (
    input  logic                          aclk,
    input  cdorb_pkg::store_cmd_t         cmd,
    input  logic [$clog2(HOLD_DEPTH)-1:0] idx,
    input  cdorb_pkg::entry_t             wr_ent,
    output cdorb_pkg::entry_t             head_ent,
    output cdorb_pkg::entry_t             rd_ent
);
    import cdorb_pkg::*;

    entry_t mem_reg [HOLD_DEPTH];

    always_ff @(posedge aclk) begin
        if (cmd.drop) begin
            for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
                mem_reg[i] <= mem_reg[i + 1];
            end
        end else if (cmd.ins) begin
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                if (i == int'(idx)) begin
                    mem_reg[i] <= wr_ent;
                end else if (i > 0 && i > int'(idx)) begin
                    mem_reg[i] <= mem_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    assign head_ent = mem_reg[0];
    assign rd_ent   = mem_reg[idx];
endmodule
`default_nettype wire

// ===== rtl/core/cdorb_emit.sv =====
// Release path: stamp resolver (shared adder), one-deep pending slot, output register.
`default_nettype none
module cdorb_emit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  cdorb_pkg::emit_req_t                 req,
    output logic                                 rdy,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [cdorb_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast
);
    import cdorb_pkg::*;

    logic        m_tvalid_reg;
    logic        pend_vld_reg;
    logic [15:0] pend_tag_reg, out_tag_reg;
    logic [9:0]  pend_len_reg, out_len_reg;
    logic [31:0] pend_stamp_reg, out_stamp_reg;
    logic        out_last_reg;
    logic [31:0] ls_reg, lf_reg;
    logic [31:0] resolved;
    logic        out_free, do_emit, do_finish, load_out;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign rdy       = !pend_vld_reg || out_free;
    assign do_emit   = req.emit && rdy;
    assign do_finish = req.finish && rdy && pend_vld_reg;
    // the held result moves out when a newer one arrives or the item ends
    assign load_out  = (do_emit && pend_vld_reg) || do_finish;
    assign resolved  = req.ent.sv ? req.ent.stamp : ls_reg + lf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            ls_reg       <= '0;
            lf_reg       <= '0;
        end else begin
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (do_emit) begin
                pend_vld_reg <= 1'b1;
                ls_reg       <= resolved;
                lf_reg       <= req.ent.ftime;
            end else if (do_finish) begin
                pend_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_tag_reg   <= pend_tag_reg;
            out_len_reg   <= pend_len_reg;
            out_stamp_reg <= pend_stamp_reg;
            out_last_reg  <= do_finish;
        end
        if (do_emit) begin
            pend_tag_reg   <= req.ent.tag;
            pend_len_reg   <= req.ent.len;
            pend_stamp_reg <= resolved;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'b0, out_stamp_reg, out_len_reg, out_tag_reg};
endmodule
`default_nettype wire

// ===== rtl/core/cdorb_ctrl.sv =====
// Sequencer: decides per packet; walks list an entry per unstalled cycle.
`default_nettype none
module cdorb_ctrl #(
    parameter int HOLD_DEPTH     = cdorb_pkg::HOLD_DEPTH_DEF,
    parameter int BACKJUMP_LIMIT = cdorb_pkg::BACKJUMP_LIMIT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cdorb_pkg::entry_t             in_ent,
    input  logic                          in_wf,
    input  logic [2:0]                    in_ptype,
    input  cdorb_pkg::entry_t             head_ent,
    input  cdorb_pkg::entry_t             rd_ent,
    output logic [$clog2(HOLD_DEPTH)-1:0] idx,
    output cdorb_pkg::entry_t             wr_ent,
    output cdorb_pkg::store_cmd_t         cmd,
    output cdorb_pkg::emit_req_t          req,
    input  logic                          emit_rdy
);
    import cdorb_pkg::*;

    localparam int IDX_W = $clog2(HOLD_DEPTH);
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, ptr_reg, ptr_next;
    logic [SEQ_W-1:0]   nro_reg, nro_next, seq_inc, jump_sum;
    logic               fback_reg, fback_next;
    entry_t             item_reg;
    logic               accept, good, in_go, head_go, back_jump, scan_end, ins_here, full;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign good      = in_wf && (in_ent.len >= LEN_W'(MIN_LEN));
    assign seq_inc   = nro_reg + SEQ_W'(1);
    assign in_go     = (seq_inc == {1'b0, item_reg.order});
    assign head_go   = (cnt_reg != '0) && (seq_inc == {1'b0, head_ent.order});
    assign jump_sum  = {1'b0, item_reg.order} + SEQ_W'(BACKJUMP_LIMIT);
    assign back_jump = (cnt_reg != '0) && (jump_sum < {1'b0, head_ent.order});
    assign scan_end  = (ptr_reg == cnt_reg);
    assign full      = (cnt_reg == CNT_W'(HOLD_DEPTH));
    // sorted by raw stamp, ties by order number
    assign ins_here  = scan_end || (rd_ent.stamp > item_reg.stamp) ||
                       ((rd_ent.stamp == item_reg.stamp) && (rd_ent.order > item_reg.order));
    assign idx       = ptr_reg[IDX_W-1:0];
    assign wr_ent    = item_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!good) state_next = ST_FINISH;
                    else if (in_ptype == PTYPE_I) state_next = ST_FLUSH;
                    else state_next = ST_DECIDE;
                end
            end
            ST_FLUSH:  if (scan_end) state_next = fback_reg ? ST_SEARCH : ST_DECIDE;
            ST_DECIDE: begin
                if (!in_go) state_next = ST_FULL;
                else if (emit_rdy) state_next = ST_RUN;
            end
            ST_RUN:    if (!head_go) state_next = ST_FINISH;
            ST_FULL:   if (!full || emit_rdy) state_next = ST_BACK;
            ST_BACK:   state_next = back_jump ? ST_FLUSH : ST_SEARCH;
            ST_SEARCH: if (ins_here) state_next = ST_INSERT;
            ST_INSERT: state_next = ST_FINISH;
            ST_FINISH: if (emit_rdy) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        nro_next   = nro_reg;
        fback_next = fback_reg;
        cmd        = '0;
        req        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    fback_next = 1'b0;
                    ptr_next   = '0;
                end
            end
            ST_FLUSH: begin
                if (scan_end) begin
                    cnt_next = '0;
                    nro_next = '1;
                    ptr_next = '0;
                end else begin
                    req.emit = 1'b1;
                    req.ent  = rd_ent;
                    if (emit_rdy) ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            ST_DECIDE: begin
                if (in_go) begin
                    req.emit = 1'b1;
                    req.ent  = item_reg;
                    if (emit_rdy) nro_next = seq_inc;
                end
            end
            ST_RUN: begin
                if (head_go) begin
                    req.emit = 1'b1;
                    req.ent  = head_ent;
                    if (emit_rdy) begin
                        cmd.drop = 1'b1;
                        cnt_next = cnt_reg - CNT_W'(1);
                        nro_next = seq_inc;
                    end
                end
            end
            ST_FULL: begin
                if (full) begin
                    req.emit = 1'b1;
                    req.ent  = head_ent;
                    if (emit_rdy) begin
                        cmd.drop = 1'b1;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            ST_BACK: begin
                ptr_next = '0;
                if (back_jump) fback_next = 1'b1;
            end
            ST_SEARCH: if (!ins_here) ptr_next = ptr_reg + CNT_W'(1);
            ST_INSERT: begin
                cmd.ins  = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_FINISH: req.finish = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            nro_reg   <= '1;
            fback_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            nro_reg   <= nro_next;
            fback_reg <= fback_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) item_reg <= in_ent;
    end
endmodule
`default_nettype wire

// ===== rtl/core/caption_display_order_reorder_buffer.sv =====
// Top level of the caption display-order reorder buffer.
// Takes one caption packet per picture and releases packets in display order, holding
// out-of-order ones in a list of HOLD_DEPTH entries sorted by stamp. One packet is taken
// at a time; s_tready is low while it is worked on. The sequencer visits the hold list
// one entry per cycle for the sorted-position search and for each flush (a flush pauses
// while the release path is not ready), and every release passes through one resolver
// and output register, so m_tready stalls hold up the packet in work.
// Dropped (malformed) packets release nothing.
`default_nettype none
module caption_display_order_reorder_buffer #(
    parameter int HOLD_DEPTH     = cdorb_pkg::HOLD_DEPTH_DEF,
    parameter int BACKJUMP_LIMIT = cdorb_pkg::BACKJUMP_LIMIT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // payload_tag, payload_len, order_number, stamp, frame_time, 4'b0
    input  logic [cdorb_pkg::S_TDATA_W-1:0]    s_tdata,
    // well_formed, picture_type, stamp_valid
    input  logic [cdorb_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_tag, out_len, out_stamp, 6'b0
    output logic [cdorb_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);
    import cdorb_pkg::*;

    entry_t                  in_ent, head_ent, rd_ent, wr_ent;
    store_cmd_t              cmd;
    emit_req_t               req;
    logic                    emit_rdy;
    logic [$clog2(HOLD_DEPTH)-1:0] idx;

    assign in_ent.tag   = s_tdata[15:0];
    assign in_ent.len   = s_tdata[25:16];
    assign in_ent.order = s_tdata[35:26];
    assign in_ent.stamp = s_tdata[67:36];
    assign in_ent.ftime = s_tdata[99:68];
    assign in_ent.sv    = s_tuser[4];

    cdorb_ctrl #(
        .HOLD_DEPTH     (HOLD_DEPTH),
        .BACKJUMP_LIMIT (BACKJUMP_LIMIT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_ent   (in_ent),
        .in_wf    (s_tuser[0]),
        .in_ptype (s_tuser[3:1]),
        .head_ent (head_ent),
        .rd_ent   (rd_ent),
        .idx      (idx),
        .wr_ent   (wr_ent),
        .cmd      (cmd),
        .req      (req),
        .emit_rdy (emit_rdy)
    );

    cdorb_store #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_store (
        .aclk     (aclk),
        .cmd      (cmd),
        .idx      (idx),
        .wr_ent   (wr_ent),
        .head_ent (head_ent),
        .rd_ent   (rd_ent)
    );

    cdorb_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .rdy      (emit_rdy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire

// ===== rtl/core/cdorb_checker.sv =====
// Port-level checks of the reorder buffer, bound to the top level.
`default_nettype none
`include "caption_display_order_reorder_buffer_defines.svh"
module cdorb_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cdorb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);
    `CDORB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `CDORB_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
    `CDORB_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while a packet is in work")
    `CDORB_ASSERT_NOW(a_idle_last, aclk, aresetn, s_tready && m_tvalid, m_tlast, "idle with an unfinished run on the output")
endmodule

bind caption_display_order_reorder_buffer cdorb_checker u_cdorb_checker (.*);
`default_nettype wire
